// ----- sv/i2p_pkg.sv -----
`default_nettype none
package i2p_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);

	localparam logic [CNT_W-1:0] CNT_ZERO = '0;
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

	typedef logic [7:0] char_t;

	typedef struct packed {
		logic  push;
		logic  pop;
		logic  clear;
		char_t data;
	} stk_cmd_t;

	typedef struct packed {
		char_t            top;
		char_t            below;
		logic [CNT_W-1:0] count;
	} stk_stat_t;

endpackage
`default_nettype wire

// ----- sv/i2p_stack.sv -----
`default_nettype none
module i2p_stack (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire i2p_pkg::stk_cmd_t    cmd,
	output i2p_pkg::stk_stat_t        stat
);

	i2p_pkg::char_t                   mem [i2p_pkg::STACK_DEPTH];
	i2p_pkg::char_t                   top_q;
	i2p_pkg::char_t                   below_q;
	logic [i2p_pkg::CNT_W-1:0]        count_q;
	logic [i2p_pkg::CNT_W-1:0]        count_d;
	logic [i2p_pkg::CNT_W-1:0]        cnt_m1;
	logic [i2p_pkg::CNT_W-1:0]        cnt_rd;
	logic [i2p_pkg::ADDR_W-1:0]       wr_addr;
	logic [i2p_pkg::ADDR_W-1:0]       rd_addr;
	logic                             wr_en;

	always_comb begin
		if (cmd.clear) begin
			count_d = i2p_pkg::CNT_ZERO;
		end else if (cmd.push) begin
			count_d = count_q + i2p_pkg::CNT_ONE;
		end else if (cmd.pop) begin
			count_d = count_q - i2p_pkg::CNT_ONE;
		end else begin
			count_d = count_q;
		end
		cnt_m1  = count_q - i2p_pkg::CNT_ONE;
		cnt_rd  = count_d - i2p_pkg::CNT_TWO;
		wr_addr = cnt_m1[i2p_pkg::ADDR_W-1:0];
		rd_addr = cnt_rd[i2p_pkg::ADDR_W-1:0];
		wr_en   = cmd.push && (count_q != i2p_pkg::CNT_ZERO);
	end

	// spill the old top below on a push; keep the entry under the top prefetched
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= top_q;
		end
		if (wr_en && (wr_addr == rd_addr)) begin
			below_q <= top_q;
		end else begin
			below_q <= mem[rd_addr];
		end
		if (cmd.push) begin
			top_q <= cmd.data;
		end else if (cmd.pop) begin
			top_q <= below_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= i2p_pkg::CNT_ZERO;
		end else begin
			count_q <= count_d;
		end
	end

	assign stat.top   = top_q;
	assign stat.below = below_q;
	assign stat.count = count_q;

endmodule
`default_nettype wire

// ----- sv/infix_to_postfix_converter_unit.sv -----
// Infix to postfix converter (shunting-yard), one character per item.
// Input channel: item_valid / item_stall carry char_code and end_marker; an
// item is taken when item_valid is high and item_stall low. item_stall is
// high from the cycle after acceptance until the item's work is done.
// Result channel: result_valid / result_stall carry out_char, is_error and
// is_last; is_last marks the final result of an item. A push or whitespace
// after no digit, and any non-end item after an error, give no result at all.
// Timing: the item is decoded in ST_START once the output register is free,
// and each result is registered in the output register. A digit, or any
// item after an error, ends in ST_START; every other item goes on to ST_BODY,
// which pops operators from the stack one pop per cycle while the output
// register is free: the top entry is held in a flip-flop and the entry below
// it is prefetched from the stack memory each cycle.
// While result_stall is high the held result stays put and the sequencer
// waits; a new item may still be taken while the last result waits.
// Reset empties the stack and clears the digit, operator and error flags;
// the stack memory itself needs no clearing. An end item returns the stack and
// the digit, operator and error flags to their reset values.
`default_nettype none
module infix_to_postfix_converter_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_stall,
	input  wire logic [7:0] char_code,
	input  wire logic       end_marker,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic [7:0]      out_char,
	output logic            is_error,
	output logic            is_last
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_BODY  = 2'd2;

	localparam i2p_pkg::char_t CH_PLUS  = 8'h2B;
	localparam i2p_pkg::char_t CH_MINUS = 8'h2D;
	localparam i2p_pkg::char_t CH_MUL   = 8'h2A;
	localparam i2p_pkg::char_t CH_DIV   = 8'h2F;
	localparam i2p_pkg::char_t CH_POW   = 8'h5E;
	localparam i2p_pkg::char_t CH_LP    = 8'h28;
	localparam i2p_pkg::char_t CH_RP    = 8'h29;
	localparam i2p_pkg::char_t CH_SP    = 8'h20;
	localparam i2p_pkg::char_t CH_NUL   = 8'h00;
	localparam i2p_pkg::char_t CH_TAB   = 8'h09;
	localparam i2p_pkg::char_t CH_CR    = 8'h0D;
	localparam i2p_pkg::char_t CH_D0    = 8'h30;
	localparam i2p_pkg::char_t CH_D9    = 8'h39;

	function automatic logic [1:0] prec_of(input i2p_pkg::char_t c);
		logic [1:0] p;
		case (c)
			CH_PLUS, CH_MINUS: p = 2'd1;
			CH_MUL, CH_DIV:    p = 2'd2;
			CH_POW:            p = 2'd3;
			default:           p = 2'd0;
		endcase
		return p;
	endfunction

	logic [1:0]          state_q;
	logic [1:0]          state_d;
	i2p_pkg::char_t      char_q;
	logic                end_q;
	logic                in_num_q, in_num_d;
	logic                prev_op_q, prev_op_d;
	logic                err_q, err_d;
	logic                out_valid_q;
	i2p_pkg::char_t      out_char_q;
	logic                out_err_q;
	logic                out_last_q;

	logic                emit;
	i2p_pkg::char_t      e_char;
	logic                e_err;
	logic                e_last;
	logic                slot_free;
	logic                accept;

	i2p_pkg::stk_cmd_t   stk_cmd;
	i2p_pkg::stk_stat_t  stk_stat;

	logic                c_digit, c_ws, c_lp, c_rp, c_op;
	logic                st_empty, st_full, st_multi;
	logic                pop_top, pop_below;
	logic                space_last;

	i2p_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (stk_cmd),
		.stat   (stk_stat)
	);

	assign accept    = item_valid && !item_stall;
	assign slot_free = !out_valid_q || !result_stall;

	always_comb begin
		c_digit   = (char_q >= CH_D0) && (char_q <= CH_D9);
		c_ws      = (char_q == CH_SP) || ((char_q >= CH_TAB) && (char_q <= CH_CR));
		c_lp      = (char_q == CH_LP);
		c_rp      = (char_q == CH_RP);
		c_op      = (prec_of(char_q) != 2'd0);
		st_empty  = (stk_stat.count == i2p_pkg::CNT_ZERO);
		st_full   = (stk_stat.count == i2p_pkg::CNT_FULL);
		st_multi  = (stk_stat.count > i2p_pkg::CNT_ONE);
		pop_top   = !st_empty && (prec_of(stk_stat.top) >= prec_of(char_q));
		pop_below = st_multi && (prec_of(stk_stat.below) >= prec_of(char_q));
		space_last = !end_q && (c_ws || (c_lp && !st_full)
			|| (c_rp && !st_empty && (stk_stat.top == CH_LP))
			|| (c_op && !prev_op_q && !pop_top && !st_full));
	end

	always_comb begin
		state_d   = state_q;
		in_num_d  = in_num_q;
		prev_op_d = prev_op_q;
		err_d     = err_q;
		emit      = 1'b0;
		e_char    = CH_NUL;
		e_err     = 1'b0;
		e_last    = 1'b0;
		stk_cmd   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				if (slot_free) begin
					if (err_q) begin
						if (end_q) begin
							emit          = 1'b1;
							e_err         = 1'b1;
							e_last        = 1'b1;
							err_d         = 1'b0;
							in_num_d      = 1'b0;
							prev_op_d     = 1'b0;
							stk_cmd.clear = 1'b1;
						end
						state_d = ST_IDLE;
					end else if (!end_q && c_digit) begin
						emit      = 1'b1;
						e_char    = char_q;
						e_last    = 1'b1;
						in_num_d  = 1'b1;
						prev_op_d = 1'b0;
						state_d   = ST_IDLE;
					end else begin
						if (in_num_q) begin
							emit     = 1'b1;
							e_char   = CH_SP;
							e_last   = space_last;
							in_num_d = 1'b0;
						end
						state_d = ST_BODY;
					end
				end
			end
			ST_BODY: begin
				if (slot_free) begin
					if (end_q) begin
						if (st_empty || (stk_stat.top == CH_LP)) begin
							emit          = 1'b1;
							e_err         = !st_empty;
							e_last        = 1'b1;
							in_num_d      = 1'b0;
							prev_op_d     = 1'b0;
							err_d         = 1'b0;
							stk_cmd.clear = 1'b1;
							state_d       = ST_IDLE;
						end else begin
							emit        = 1'b1;
							e_char      = stk_stat.top;
							stk_cmd.pop = 1'b1;
						end
					end else if (c_ws) begin
						prev_op_d = 1'b0;
						state_d   = ST_IDLE;
					end else if (c_lp && !st_full) begin
						prev_op_d    = 1'b0;
						stk_cmd.push = 1'b1;
						stk_cmd.data = char_q;
						state_d      = ST_IDLE;
					end else if (c_rp && !st_empty) begin
						prev_op_d   = 1'b0;
						stk_cmd.pop = 1'b1;
						if (stk_stat.top == CH_LP) begin
							state_d = ST_IDLE;
						end else begin
							emit   = 1'b1;
							e_char = stk_stat.top;
							e_last = st_multi && (stk_stat.below == CH_LP);
						end
					end else if (c_op && !prev_op_q && pop_top) begin
						emit        = 1'b1;
						e_char      = stk_stat.top;
						e_last      = !pop_below;
						stk_cmd.pop = 1'b1;
					end else if (c_op && !prev_op_q && !st_full) begin
						prev_op_d    = 1'b1;
						stk_cmd.push = 1'b1;
						stk_cmd.data = char_q;
						state_d      = ST_IDLE;
					end else begin
						// fail: flag, empty the stack, ignore until the end item
						emit          = 1'b1;
						e_err         = 1'b1;
						e_last        = 1'b1;
						in_num_d      = 1'b0;
						prev_op_d     = 1'b0;
						err_d         = 1'b1;
						stk_cmd.clear = 1'b1;
						state_d       = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_num_q    <= 1'b0;
			prev_op_q   <= 1'b0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			in_num_q  <= in_num_d;
			prev_op_q <= prev_op_d;
			err_q     <= err_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_q <= char_code;
			end_q  <= end_marker;
		end
		if (emit) begin
			out_char_q <= e_char;
			out_err_q  <= e_err;
			out_last_q <= e_last;
		end
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;
	assign out_char     = out_char_q;
	assign is_error     = out_err_q;
	assign is_last      = out_last_q;

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS = 45;

	localparam i2p_pkg::char_t CH_NUL = 8'h00;
	localparam i2p_pkg::char_t CH_TAB = 8'h09;
	localparam i2p_pkg::char_t CH_LF = 8'h0A;
	localparam i2p_pkg::char_t CH_VT = 8'h0B;
	localparam i2p_pkg::char_t CH_FF = 8'h0C;
	localparam i2p_pkg::char_t CH_CR = 8'h0D;
	localparam i2p_pkg::char_t CH_SPACE = 8'h20;
	localparam i2p_pkg::char_t CH_LPAR = 8'h28;
	localparam i2p_pkg::char_t CH_RPAR = 8'h29;
	localparam i2p_pkg::char_t CH_STAR = 8'h2A;
	localparam i2p_pkg::char_t CH_PLUS = 8'h2B;
	localparam i2p_pkg::char_t CH_MINUS = 8'h2D;
	localparam i2p_pkg::char_t CH_SLASH = 8'h2F;
	localparam i2p_pkg::char_t CH_ZERO = 8'h30;
	localparam i2p_pkg::char_t CH_NINE = 8'h39;
	localparam i2p_pkg::char_t CH_CARET = 8'h5E;

	typedef struct {
		i2p_pkg::char_t ch;
		logic  fin;
	} infix_item_t;

	typedef struct {
		i2p_pkg::char_t ch;
		logic  err;
		logic  last;
	} postfix_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [7:0]  char_code = 8'h00;
	logic        end_marker = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [7:0]  out_char;
	logic        is_error;
	logic        is_last;

	infix_item_t pending_q[$];
	postfix_t    postfix_q[$];
	i2p_pkg::char_t expr_chars[$];
	infix_item_t next_item;

	i2p_pkg::char_t op_stk[i2p_pkg::STACK_DEPTH];
	int          stk_cnt = 0;
	logic        in_run = 1'b0;
	logic        prev_op = 1'b0;
	logic        err_seen = 1'b0;

	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          mismatches = 0;
	int          items_added = 0;
	int          quiet_cycles = 0;

	infix_to_postfix_converter_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.char_code   (char_code),
		.end_marker  (end_marker),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.out_char    (out_char),
		.is_error    (is_error),
		.is_last     (is_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int prec_of_op(i2p_pkg::char_t c);
		case (c)
			CH_PLUS, CH_MINUS: return 1;
			CH_STAR, CH_SLASH: return 2;
			CH_CARET: return 3;
			default: return 0;
		endcase
	endfunction

	function automatic logic is_space_char(i2p_pkg::char_t c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic i2p_pkg::char_t pick_op(int k);
		case (k)
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_STAR;
			3: return CH_SLASH;
			default: return CH_CARET;
		endcase
	endfunction

	function automatic i2p_pkg::char_t pick_space(int k);
		case (k)
			0: return CH_TAB;
			1: return CH_LF;
			2: return CH_VT;
			3: return CH_FF;
			4: return CH_CR;
			default: return CH_SPACE;
		endcase
	endfunction

	function automatic void emit_postfix(i2p_pkg::char_t ch, logic err);
		postfix_t r;
		r.ch = ch;
		r.err = err;
		r.last = 1'b0;
		postfix_q.push_back(r);
	endfunction

	function automatic void close_run();
		if (in_run) begin
			emit_postfix(CH_SPACE, 1'b0);
			in_run = 1'b0;
		end
	endfunction

	function automatic void abort_expr();
		emit_postfix(CH_NUL, 1'b1);
		stk_cnt = 0;
		in_run = 1'b0;
		prev_op = 1'b0;
		err_seen = 1'b1;
	endfunction

	function automatic void predict_postfix(i2p_pkg::char_t c, logic fin);
		int first;
		first = postfix_q.size();
		if (fin) begin
			if (err_seen) begin
				emit_postfix(CH_NUL, 1'b1);
			end else begin
				close_run();
				while (stk_cnt > 0 && op_stk[stk_cnt-1] != CH_LPAR) begin
					emit_postfix(op_stk[stk_cnt-1], 1'b0);
					stk_cnt--;
				end
				emit_postfix(CH_NUL, stk_cnt != 0);
			end
			stk_cnt = 0;
			in_run = 1'b0;
			prev_op = 1'b0;
			err_seen = 1'b0;
		end else if (err_seen) begin
		end else if (c >= CH_ZERO && c <= CH_NINE) begin
			emit_postfix(c, 1'b0);
			in_run = 1'b1;
			prev_op = 1'b0;
		end else if (is_space_char(c)) begin
			close_run();
			prev_op = 1'b0;
		end else if (c == CH_LPAR) begin
			close_run();
			prev_op = 1'b0;
			if (stk_cnt >= i2p_pkg::STACK_DEPTH) begin
				abort_expr();
			end else begin
				op_stk[stk_cnt] = c;
				stk_cnt++;
			end
		end else if (c == CH_RPAR) begin
			close_run();
			prev_op = 1'b0;
			while (stk_cnt > 0 && op_stk[stk_cnt-1] != CH_LPAR) begin
				emit_postfix(op_stk[stk_cnt-1], 1'b0);
				stk_cnt--;
			end
			if (stk_cnt == 0)
				abort_expr();
			else
				stk_cnt--;
		end else if (prec_of_op(c) > 0) begin
			close_run();
			if (prev_op) begin
				abort_expr();
			end else begin
				while (stk_cnt > 0 && prec_of_op(op_stk[stk_cnt-1]) >= prec_of_op(c)) begin
					emit_postfix(op_stk[stk_cnt-1], 1'b0);
					stk_cnt--;
				end
				if (stk_cnt >= i2p_pkg::STACK_DEPTH) begin
					abort_expr();
				end else begin
					op_stk[stk_cnt] = c;
					stk_cnt++;
					prev_op = 1'b1;
				end
			end
		end else begin
			close_run();
			abort_expr();
		end
		if (postfix_q.size() > first)
			postfix_q[postfix_q.size()-1].last = 1'b1;
	endfunction

	task automatic report_mismatch(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch: %s", $realtime, what);
	endtask

	task automatic add_item(i2p_pkg::char_t ch, logic fin);
		infix_item_t it;
		it.ch = ch;
		it.fin = fin;
		pending_q.push_back(it);
		items_added++;
	endtask

	task automatic add_digits();
		repeat ($urandom_range(1, 3))
			expr_chars.push_back(CH_ZERO + i2p_pkg::char_t'($urandom_range(9)));
	endtask

	task automatic maybe_space();
		if ($urandom_range(3) == 0)
			expr_chars.push_back(pick_space($urandom_range(5)));
	endtask

	task automatic add_operand(int depth);
		if (depth > 0 && $urandom_range(2) == 0) begin
			expr_chars.push_back(CH_LPAR);
			add_sum(depth - 1);
			expr_chars.push_back(CH_RPAR);
		end else begin
			add_digits();
		end
	endtask

	task automatic add_sum(int depth);
		add_operand(depth);
		repeat ($urandom_range(0, 3)) begin
			maybe_space();
			expr_chars.push_back(pick_op($urandom_range(4)));
			maybe_space();
			add_operand(depth);
		end
	endtask

	task automatic add_nesting(int k);
		repeat (k) expr_chars.push_back(CH_LPAR);
		add_digits();
		expr_chars.push_back(pick_op($urandom_range(4)));
		add_digits();
		repeat (k) expr_chars.push_back(CH_RPAR);
	endtask

	task automatic flush_expr();
		foreach (expr_chars[i])
			add_item(expr_chars[i], 1'b0);
		add_item(i2p_pkg::char_t'($urandom_range(255)), 1'b1);
		expr_chars.delete();
	endtask

	task automatic add_expression();
		int pos;
		if ($urandom_range(99) < 8)
			add_nesting($urandom_range(28, 34));
		else
			add_sum($urandom_range(0, 3));
		if ($urandom_range(99) < 20) begin
			pos = $urandom_range(expr_chars.size() - 1);
			case ($urandom_range(3))
				0: expr_chars[pos] = i2p_pkg::char_t'($urandom_range(255));
				1: expr_chars[pos] = pick_op($urandom_range(4));
				2: expr_chars.insert(pos, $urandom_range(1) ? CH_LPAR : CH_RPAR);
				default: expr_chars.insert(pos, pick_op($urandom_range(4)));
			endcase
		end
		flush_expr();
	endtask

	task automatic add_directed();
		add_item("9", 1'b0);
		add_item(CH_TAB, 1'b0);
		add_item("0", 1'b0);
		add_item(CH_LF, 1'b0);
		add_item(CH_PLUS, 1'b0);
		add_item(CH_VT, 1'b0);
		add_item("1", 1'b0);
		add_item(CH_FF, 1'b0);
		add_item(CH_STAR, 1'b0);
		add_item(CH_CR, 1'b0);
		add_item(CH_LPAR, 1'b0);
		add_item("2", 1'b0);
		add_item(CH_MINUS, 1'b0);
		add_item("3", 1'b0);
		add_item(CH_RPAR, 1'b0);
		add_item(CH_CARET, 1'b0);
		add_item("4", 1'b0);
		add_item(CH_SLASH, 1'b0);
		add_item("5", 1'b0);
		add_item(8'hFF, 1'b1);
		add_item(CH_RPAR, 1'b0);
		add_item(8'hFF, 1'b0);
		add_item(CH_NUL, 1'b1);
		add_item(CH_LPAR, 1'b0);
		add_item("7", 1'b0);
		add_item(CH_NUL, 1'b1);
		add_item("1", 1'b0);
		add_item(CH_PLUS, 1'b0);
		add_item(CH_STAR, 1'b0);
		add_item(CH_NUL, 1'b1);
		add_item(CH_NUL, 1'b0);
		add_item(CH_NUL, 1'b1);
		add_nesting(i2p_pkg::STACK_DEPTH);
		flush_expr();
		add_nesting(i2p_pkg::STACK_DEPTH + 1);
		flush_expr();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			char_code <= 8'h00;
			end_marker <= 1'b0;
		end else if (!item_valid || !item_stall) begin
			if (item_valid)
				predict_postfix(char_code, end_marker);
			if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_item = pending_q.pop_front();
				item_valid <= 1'b1;
				char_code <= next_item.ch;
				end_marker <= next_item.fin;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		postfix_t exp_r;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (postfix_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result char %h err %b last %b",
						out_char, is_error, is_last));
				end else begin
					exp_r = postfix_q.pop_front();
					if (out_char !== exp_r.ch || is_error !== exp_r.err || is_last !== exp_r.last)
						report_mismatch($sformatf(
							"expected char %h err %b last %b, got char %h err %b last %b",
							exp_r.ch, exp_r.err, exp_r.last, out_char, is_error, is_last));
				end
			end
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int phase;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 79; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 79; end
				default: begin send_idle_pct = 31; recv_stall_pct = 31; end
			endcase
			items_added = 0;
			if (phase == 0)
				add_directed();
			items_added = 0;
			while (items_added < PHASE_ITEMS)
				add_expression();
			wait (pending_q.size() == 0 && !item_valid);
			wait (postfix_q.size() == 0);
			repeat (40) @(posedge clk);
		end
		if (mismatches == 0 && postfix_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
sv/i2p_pkg.sv
sv/i2p_stack.sv
sv/infix_to_postfix_converter_unit.sv
dv/tb_top.sv
